[sv/pme_pkg.sv]
// Package with the shared constants, types and helpers of the priority mailbox engine.
`timescale 1ns / 1ps
package pme_pkg;

    localparam int MAILBOX_COUNT = 8;
    localparam int POOL_DEPTH    = 128;
    localparam int DATA_WIDTH    = 32;

    localparam int BOX_W  = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int LINK_W = $clog2(POOL_DEPTH + 1);

    // The null link is the first index past the pool.
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_SEND    = 2'd2,
        OP_RECV    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_BOX   = 3'd1,
        ST_NOT_USED = 3'd2,
        ST_POOL_FULL = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [2:0]  id;
        logic        mode;
        logic [31:0] data;
        logic [7:0]  prio;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [2:0]  created_id;
        logic [31:0] data;
        logic        not_empty;
    } t_res;

    function automatic logic link_null(input logic [LINK_W-1:0] l);
        return l >= NULL_LINK;
    endfunction

endpackage

[sv/priority_mailbox_engine_top.sv]
// Top level of the priority mailbox engine: command queue, sequencer and result queue.
`timescale 1ns / 1ps
// Eight mailboxes share a pool of 128 message entries. Transactions enter a
// two-entry command queue and results leave through a two-entry result queue,
// so both sides stall independently. Create, destroy of an empty mailbox and
// failed commands go from idle straight to the done state; receive first
// reads the head entry. A send scans the entry-used bits one entry per cycle
// from the lowest index, then walks the mailbox list in arrival order or, in
// priority order, also checks the priority of each next entry, paced by the
// registered read of the link and priority memories. Destroy frees the chain
// entry by entry through a read and a check state for each entry.
module priority_mailbox_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_mailbox_id,
    input  logic        i_priority_mode,
    input  logic [31:0] i_send_data,
    input  logic [7:0]  i_send_priority,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [2:0]  o_created_id,
    output logic [31:0] o_received_data,
    output logic        o_not_empty
);

    logic          w_cmd_valid;
    pme_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;
    logic          w_res_full;
    logic          w_res_push;
    pme_pkg::t_res w_res_in;
    pme_pkg::t_res w_res_out;

    pme_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_operation(i_operation), .i_mailbox_id(i_mailbox_id),
        .i_priority_mode(i_priority_mode), .i_send_data(i_send_data),
        .i_send_priority(i_send_priority),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_cmd_pop)
    );

    pme_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_pop(w_cmd_pop),
        .i_res_full(w_res_full), .o_res_push(w_res_push), .o_res(w_res_in)
    );

    pme_resq u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_res_push), .i_res(w_res_in),
        .o_full(w_res_full), .o_empty(empty), .i_pop(pop), .o_res(w_res_out)
    );

    assign o_status        = w_res_out.status;
    assign o_created_id    = w_res_out.created_id;
    assign o_received_data = w_res_out.data;
    assign o_not_empty     = w_res_out.not_empty;

endmodule

[sv/pme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/pme_front.sv]
// Front end: accepts incoming transactions and packs them into a two-entry command queue.
`timescale 1ns / 1ps
module pme_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_operation,
    input  logic [2:0]    i_mailbox_id,
    input  logic          i_priority_mode,
    input  logic [31:0]   i_send_data,
    input  logic [7:0]    i_send_priority,
    output logic          o_cmd_valid,
    output pme_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    pme_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_wr;
    logic          w_rd;
    pme_pkg::t_cmd w_cmd;

    always_comb begin
        w_cmd.op   = pme_pkg::t_op'(i_operation);
        w_cmd.id   = i_mailbox_id;
        w_cmd.mode = i_priority_mode;
        w_cmd.data = i_send_data;
        w_cmd.prio = i_send_priority;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

[sv/pme_resq.sv]
// Two-entry result queue that feeds the output side.
`timescale 1ns / 1ps
module pme_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pme_pkg::t_res i_res,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output pme_pkg::t_res o_res
);

    pme_pkg::t_res r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_q[r_wp] <= i_res;
                r_wp      <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

[sv/pme_back.sv]
// Back end: sequencer that carries out mailbox commands over the entry pool memories.
`timescale 1ns / 1ps
module pme_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  pme_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output pme_pkg::t_res o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_HEAD_RD, S_HEAD_CHK, S_WALK_RD, S_WALK_CHK,
        S_PRIO_RD, S_PRIO_CHK, S_LINK_E, S_LINK_CUR, S_FREE_RD, S_FREE_CHK,
        S_RECV_RD, S_RECV_CHK, S_DONE
    } t_state;

    t_state                          r_state;
    pme_pkg::t_cmd                   r_cmd;
    pme_pkg::t_res                   r_res;
    logic [pme_pkg::BOX_W-1:0]       r_box;
    logic [pme_pkg::LINK_W-1:0]      r_cur;
    logic [pme_pkg::LINK_W-1:0]      r_nx;
    logic [pme_pkg::IDX_W-1:0]       r_e;
    logic [pme_pkg::IDX_W-1:0]       r_scan;
    logic [pme_pkg::IDX_W-1:0]       r_raddr;
    logic                            r_at_head;
    logic                            r_in_use [pme_pkg::MAILBOX_COUNT];
    logic                            r_mode   [pme_pkg::MAILBOX_COUNT];
    logic [pme_pkg::LINK_W-1:0]      r_head   [pme_pkg::MAILBOX_COUNT];
    logic [pme_pkg::POOL_DEPTH-1:0]  r_used;

    logic                            w_free_found;
    logic [pme_pkg::BOX_W-1:0]       w_free_idx;
    logic [pme_pkg::BOX_W-1:0]       w_box;
    logic                            w_live;
    logic [pme_pkg::LINK_W-1:0]      w_head;
    pme_pkg::t_status                w_status;
    logic [2:0]                      w_created;

    logic                            w_dat_we;
    logic                            w_nx_we;
    logic [pme_pkg::IDX_W-1:0]       w_nx_waddr;
    logic [pme_pkg::LINK_W-1:0]      w_nx_wdata;
    logic [pme_pkg::LINK_W-1:0]      w_nx_rdata;
    logic [7:0]                      w_pr_rdata;
    logic [pme_pkg::DATA_WIDTH-1:0]  w_dt_rdata;

    // Lowest free mailbox.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = pme_pkg::MAILBOX_COUNT - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = pme_pkg::BOX_W'(i);
            end
        end
    end

    assign w_box  = pme_pkg::BOX_W'(i_cmd.id);
    assign w_live = (int'(i_cmd.id) < pme_pkg::MAILBOX_COUNT) && r_in_use[w_box];
    assign w_head = r_head[w_box];

    // Status and created index that are known as soon as a command is taken.
    always_comb begin
        w_status  = pme_pkg::ST_OK;
        w_created = 3'd0;
        if (i_cmd.op == pme_pkg::OP_CREATE) begin
            if (w_free_found) begin
                w_created = 3'(w_free_idx);
            end else begin
                w_status = pme_pkg::ST_NO_BOX;
            end
        end else if (!w_live) begin
            w_status = pme_pkg::ST_NOT_USED;
        end else if (i_cmd.op == pme_pkg::OP_RECV && pme_pkg::link_null(w_head)) begin
            w_status = pme_pkg::ST_EMPTY;
        end
    end

    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_push = (r_state == S_DONE) && !i_res_full;
    assign o_res      = r_res;

    always_comb begin
        w_dat_we   = (r_state == S_SCAN) && !r_used[r_scan];
        w_nx_we    = 1'b0;
        w_nx_waddr = r_e;
        w_nx_wdata = r_nx;
        if (r_state == S_LINK_E) begin
            w_nx_we = 1'b1;
        end else if (r_state == S_LINK_CUR) begin
            w_nx_we    = 1'b1;
            w_nx_waddr = r_cur[pme_pkg::IDX_W-1:0];
            w_nx_wdata = pme_pkg::LINK_W'(r_e);
        end
    end

    pme_ram #(.WIDTH(pme_pkg::LINK_W), .DEPTH(pme_pkg::POOL_DEPTH)) u_next_ram (
        .i_clk(i_clk), .i_we(w_nx_we), .i_waddr(w_nx_waddr), .i_wdata(w_nx_wdata),
        .i_raddr(r_raddr), .o_rdata(w_nx_rdata)
    );

    pme_ram #(.WIDTH(8), .DEPTH(pme_pkg::POOL_DEPTH)) u_prio_ram (
        .i_clk(i_clk), .i_we(w_dat_we), .i_waddr(r_scan), .i_wdata(r_cmd.prio),
        .i_raddr(r_raddr), .o_rdata(w_pr_rdata)
    );

    pme_ram #(.WIDTH(pme_pkg::DATA_WIDTH), .DEPTH(pme_pkg::POOL_DEPTH)) u_data_ram (
        .i_clk(i_clk), .i_we(w_dat_we), .i_waddr(r_scan),
        .i_wdata(pme_pkg::DATA_WIDTH'(r_cmd.data)),
        .i_raddr(r_raddr), .o_rdata(w_dt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            for (int i = 0; i < pme_pkg::MAILBOX_COUNT; i++) begin
                r_in_use[i] <= 1'b0;
                r_mode[i]   <= 1'b0;
                r_head[i]   <= pme_pkg::NULL_LINK;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_box <= w_box;
                        r_res.status     <= w_status;
                        r_res.created_id <= w_created;
                        r_res.data       <= '0;
                        r_res.not_empty  <= 1'b0;
                        r_state <= S_DONE;
                        if (i_cmd.op == pme_pkg::OP_CREATE) begin
                            if (w_free_found) begin
                                r_in_use[w_free_idx] <= 1'b1;
                                r_mode[w_free_idx]   <= i_cmd.mode;
                                r_head[w_free_idx]   <= pme_pkg::NULL_LINK;
                            end
                        end else if (w_live) begin
                            unique case (i_cmd.op)
                                pme_pkg::OP_DESTROY: begin
                                    if (pme_pkg::link_null(w_head)) begin
                                        r_in_use[w_box] <= 1'b0;
                                        r_mode[w_box]   <= 1'b0;
                                    end else begin
                                        r_raddr <= w_head[pme_pkg::IDX_W-1:0];
                                        r_state <= S_FREE_RD;
                                    end
                                end
                                pme_pkg::OP_SEND: begin
                                    r_scan  <= '0;
                                    r_state <= S_SCAN;
                                end
                                default: begin
                                    if (!pme_pkg::link_null(w_head)) begin
                                        r_raddr <= w_head[pme_pkg::IDX_W-1:0];
                                        r_state <= S_RECV_RD;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_used[r_scan]) begin
                        r_e            <= r_scan;
                        r_used[r_scan] <= 1'b1;
                        if (pme_pkg::link_null(r_head[r_box])) begin
                            r_nx      <= pme_pkg::NULL_LINK;
                            r_at_head <= 1'b1;
                            r_state   <= S_LINK_E;
                        end else begin
                            r_cur   <= r_head[r_box];
                            r_raddr <= r_head[r_box][pme_pkg::IDX_W-1:0];
                            r_state <= r_mode[r_box] ? S_HEAD_RD : S_WALK_RD;
                        end
                    end else if (r_scan == pme_pkg::IDX_W'(pme_pkg::POOL_DEPTH - 1)) begin
                        r_res.status    <= pme_pkg::ST_POOL_FULL;
                        r_res.not_empty <= !pme_pkg::link_null(r_head[r_box]);
                        r_state         <= S_DONE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_HEAD_RD: r_state <= S_HEAD_CHK;
                S_HEAD_CHK: begin
                    if (w_pr_rdata > r_cmd.prio) begin
                        r_nx      <= r_cur;
                        r_at_head <= 1'b1;
                        r_state   <= S_LINK_E;
                    end else begin
                        r_state <= S_WALK_RD;
                    end
                end
                S_WALK_RD: r_state <= S_WALK_CHK;
                S_WALK_CHK: begin
                    r_nx <= w_nx_rdata;
                    if (pme_pkg::link_null(w_nx_rdata)) begin
                        r_at_head <= 1'b0;
                        r_state   <= S_LINK_E;
                    end else if (r_mode[r_box]) begin
                        r_raddr <= w_nx_rdata[pme_pkg::IDX_W-1:0];
                        r_state <= S_PRIO_RD;
                    end else begin
                        r_cur   <= w_nx_rdata;
                        r_raddr <= w_nx_rdata[pme_pkg::IDX_W-1:0];
                        r_state <= S_WALK_RD;
                    end
                end
                S_PRIO_RD: r_state <= S_PRIO_CHK;
                S_PRIO_CHK: begin
                    // A strictly larger number behind the current entry ends the walk.
                    if (w_pr_rdata > r_cmd.prio) begin
                        r_at_head <= 1'b0;
                        r_state   <= S_LINK_E;
                    end else begin
                        r_cur   <= r_nx;
                        r_state <= S_WALK_RD;
                    end
                end
                S_LINK_E: begin
                    if (r_at_head) begin
                        r_head[r_box]   <= pme_pkg::LINK_W'(r_e);
                        r_res.not_empty <= 1'b1;
                        r_state         <= S_DONE;
                    end else begin
                        r_state <= S_LINK_CUR;
                    end
                end
                S_LINK_CUR: begin
                    r_res.not_empty <= 1'b1;
                    r_state         <= S_DONE;
                end
                S_FREE_RD: r_state <= S_FREE_CHK;
                S_FREE_CHK: begin
                    r_used[r_raddr] <= 1'b0;
                    if (pme_pkg::link_null(w_nx_rdata)) begin
                        r_in_use[r_box] <= 1'b0;
                        r_mode[r_box]   <= 1'b0;
                        r_head[r_box]   <= pme_pkg::NULL_LINK;
                        r_state         <= S_DONE;
                    end else begin
                        r_raddr <= w_nx_rdata[pme_pkg::IDX_W-1:0];
                        r_state <= S_FREE_RD;
                    end
                end
                S_RECV_RD: r_state <= S_RECV_CHK;
                S_RECV_CHK: begin
                    r_res.data      <= 32'(w_dt_rdata);
                    r_res.not_empty <= !pme_pkg::link_null(w_nx_rdata);
                    r_head[r_box]   <= w_nx_rdata;
                    r_used[r_raddr] <= 1'b0;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_push_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (r_state == S_DONE) && !i_res_full)
        else $error("result pushed outside the done state");

    a_head_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK_E) && r_at_head |=> !pme_pkg::link_null(r_head[$past(r_box)]))
        else $error("insert at head left the mailbox empty");

    a_scan_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && !r_used[r_scan] |=> r_used[$past(r_scan)])
        else $error("allocated entry not marked used");
`endif

endmodule

[tb/tb_priority_mailbox_engine_top.sv]
// Self-checking testbench for the priority mailbox engine top level.
`timescale 1ns / 1ps
module tb_priority_mailbox_engine_top;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int NULL_IDX    = pme_pkg::POOL_DEPTH;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_operation;
    logic [2:0]  i_mailbox_id;
    logic        i_priority_mode;
    logic [31:0] i_send_data;
    logic [7:0]  i_send_priority;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status;
    logic [2:0]  o_created_id;
    logic [31:0] o_received_data;
    logic        o_not_empty;

    priority_mailbox_engine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_operation(i_operation), .i_mailbox_id(i_mailbox_id),
        .i_priority_mode(i_priority_mode), .i_send_data(i_send_data),
        .i_send_priority(i_send_priority), .empty(empty), .pop(pop),
        .o_status(o_status), .o_created_id(o_created_id),
        .o_received_data(o_received_data), .o_not_empty(o_not_empty)
    );

    // Shadow copy of the mailbox state.
    logic        mb_used [pme_pkg::MAILBOX_COUNT];
    logic        mb_prio [pme_pkg::MAILBOX_COUNT];
    int          mb_head [pme_pkg::MAILBOX_COUNT];
    logic        pool_used [pme_pkg::POOL_DEPTH];
    int          pool_next [pme_pkg::POOL_DEPTH];
    logic [7:0]  pool_prio [pme_pkg::POOL_DEPTH];
    logic [31:0] pool_data [pme_pkg::POOL_DEPTH];

    pme_pkg::t_cmd cmd_queue[$];
    pme_pkg::t_res expected_results[$];
    int   errors = 0;
    int   cycle_count = 0;
    int   results_seen = 0;
    int   pool_full_seen = 0;
    int   hold_cycles = 0;
    logic stim_done;
    logic in_taken = 1'b0;

    function automatic pme_pkg::t_res mailbox_apply(input pme_pkg::t_cmd c);
        pme_pkg::t_res r;
        int e, cur, nx, h, k;
        logic live;
        r = '0;
        r.status = pme_pkg::ST_OK;
        live = mb_used[c.id];
        if (c.op == pme_pkg::OP_CREATE) begin
            r.status = pme_pkg::ST_NO_BOX;
            for (k = 0; k < pme_pkg::MAILBOX_COUNT; k++) begin
                if (!mb_used[k]) begin
                    mb_used[k] = 1'b1;
                    mb_prio[k] = c.mode;
                    mb_head[k] = NULL_IDX;
                    r.status = pme_pkg::ST_OK;
                    r.created_id = k[2:0];
                    break;
                end
            end
        end else if (!live) begin
            r.status = pme_pkg::ST_NOT_USED;
        end else if (c.op == pme_pkg::OP_DESTROY) begin
            e = mb_head[c.id];
            while (e < NULL_IDX) begin
                pool_used[e] = 1'b0;
                e = pool_next[e];
            end
            mb_used[c.id] = 1'b0;
            mb_prio[c.id] = 1'b0;
            mb_head[c.id] = NULL_IDX;
        end else if (c.op == pme_pkg::OP_SEND) begin
            e = NULL_IDX;
            for (k = 0; k < pme_pkg::POOL_DEPTH; k++) begin
                if (!pool_used[k]) begin
                    e = k;
                    break;
                end
            end
            if (e == NULL_IDX) begin
                r.status = pme_pkg::ST_POOL_FULL;
            end else begin
                pool_used[e] = 1'b1;
                pool_data[e] = c.data;
                pool_prio[e] = c.prio;
                pool_next[e] = NULL_IDX;
                cur = mb_head[c.id];
                if (cur == NULL_IDX || (mb_prio[c.id] && pool_prio[cur] > c.prio)) begin
                    pool_next[e] = cur;
                    mb_head[c.id] = e;
                end else begin
                    forever begin
                        nx = pool_next[cur];
                        if (nx == NULL_IDX || (mb_prio[c.id] && pool_prio[nx] > c.prio))
                            break;
                        cur = nx;
                    end
                    pool_next[e] = pool_next[cur];
                    pool_next[cur] = e;
                end
            end
            r.not_empty = (mb_head[c.id] != NULL_IDX);
        end else begin
            h = mb_head[c.id];
            if (h == NULL_IDX) begin
                r.status = pme_pkg::ST_EMPTY;
            end else begin
                r.data = pool_data[h];
                mb_head[c.id] = pool_next[h];
                pool_used[h] = 1'b0;
                r.not_empty = (mb_head[c.id] != NULL_IDX);
            end
        end
        return r;
    endfunction

    function automatic pme_pkg::t_cmd make_cmd(input pme_pkg::t_op op, input int id,
                                               input logic mode, input logic [31:0] data,
                                               input logic [7:0] prio);
        pme_pkg::t_cmd c;
        c.op = op;
        c.id = id[2:0];
        c.mode = mode;
        c.data = data;
        c.prio = prio;
        return c;
    endfunction

    function automatic pme_pkg::t_cmd random_cmd(input int busy_box);
        pme_pkg::t_op op;
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)       op = pme_pkg::OP_CREATE;
        else if (pick < 9)  op = pme_pkg::OP_DESTROY;
        else if (pick < 60) op = pme_pkg::OP_SEND;
        else                op = pme_pkg::OP_RECV;
        // Mostly steer traffic to a few mailboxes so lists grow deep.
        return make_cmd(op, ($urandom_range(99) < 80) ? busy_box : int'($urandom_range(7)),
                        1'($urandom_range(1)), $urandom,
                        ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stimulus.
    initial begin
        int k;
        stim_done = 1'b0;
        // Directed part: create both modes, all error paths, field extremes.
        cmd_queue.push_back(make_cmd(pme_pkg::OP_RECV, 0, 1'b0, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 7, 1'b0, '1, '1));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_DESTROY, 3, 1'b0, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_CREATE, 5, 1'b0, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_CREATE, 2, 1'b1, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_RECV, 0, 1'b0, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 0, 1'b0, 32'hFFFF_FFFF, 8'hFF));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 0, 1'b0, 32'h0000_0000, 8'h00));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 1, 1'b0, 32'hAAAA_5555, 8'h80));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 1, 1'b0, 32'h5555_AAAA, 8'h01));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 1, 1'b0, 32'h1234_5678, 8'h80));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 1, 1'b0, 32'h0BAD_F00D, 8'hFF));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_RECV, 1, 1'b0, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_RECV, 0, 1'b0, '0, '0));
        for (k = 0; k < 7; k++)
            cmd_queue.push_back(make_cmd(pme_pkg::OP_CREATE, 0, k[0], '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_DESTROY, 1, 1'b0, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 1, 1'b0, 32'h1, 8'h1));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_RECV, 7, 1'b0, '0, '0));
        // Fill the pool to hit the pool-full case, then drain it by destroy.
        for (k = 0; k < pme_pkg::POOL_DEPTH + 2; k++)
            cmd_queue.push_back(make_cmd(pme_pkg::OP_SEND, 0, 1'b0, $urandom,
                                         8'($urandom)));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_DESTROY, 0, 1'b0, '0, '0));
        cmd_queue.push_back(make_cmd(pme_pkg::OP_CREATE, 0, 1'b1, '0, '0));
        for (k = 0; k < 600; k++)
            cmd_queue.push_back(random_cmd((k / 150) % 3));
        stim_done = 1'b1;
    end

    // Driver: changes inputs on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !in_taken) begin
            // Hold the offered transaction until it is taken.
        end else begin
            if (cmd_queue.size() > 0 &&
                (cycle_count < 3000 || $urandom_range(99) >= 21)) begin
                pme_pkg::t_cmd c;
                c = cmd_queue.pop_front();
                push <= 1'b1;
                i_operation <= c.op;
                i_mailbox_id <= c.id;
                i_priority_mode <= c.mode;
                i_send_data <= c.data;
                i_send_priority <= c.prio;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver pacing: one long hold-off early on, random stalls later.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (cycle_count > 400 && hold_cycles < 600) begin
            hold_cycles <= hold_cycles + 1;
            pop <= 1'b0;
        end else begin
            pop <= (cycle_count < 3000) ? 1'b1 : ($urandom_range(99) >= 21);
        end
    end

    // Monitor: predicts each accepted transaction and checks each accepted result.
    always @(posedge i_clk) begin
        in_taken = i_rst_n && push && !full;
        if (in_taken) begin
            expected_results.push_back(mailbox_apply({pme_pkg::t_op'(i_operation),
                i_mailbox_id, i_priority_mode, i_send_data, i_send_priority}));
        end
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    errors = errors + 1;
                end else begin
                    pme_pkg::t_res x;
                    x = expected_results.pop_front();
                    results_seen <= results_seen + 1;
                    if (x.status == pme_pkg::ST_POOL_FULL)
                        pool_full_seen <= pool_full_seen + 1;
                    if (o_status != x.status) begin
                        $error("status expected %0d actual %0d", x.status, o_status);
                        errors = errors + 1;
                    end
                    if (o_created_id != x.created_id) begin
                        $error("created_id expected %0d actual %0d", x.created_id,
                               o_created_id);
                        errors = errors + 1;
                    end
                    if (o_received_data != x.data) begin
                        $error("received_data expected %h actual %h", x.data,
                               o_received_data);
                        errors = errors + 1;
                    end
                    if (o_not_empty != x.not_empty) begin
                        $error("not_empty expected %0d actual %0d", x.not_empty,
                               o_not_empty);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    initial begin
        int k;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_operation = pme_pkg::OP_CREATE;
        i_mailbox_id = '0;
        i_priority_mode = 1'b0;
        i_send_data = '0;
        i_send_priority = '0;
        for (k = 0; k < pme_pkg::MAILBOX_COUNT; k++) begin
            mb_used[k] = 1'b0;
            mb_prio[k] = 1'b0;
            mb_head[k] = NULL_IDX;
        end
        for (k = 0; k < pme_pkg::POOL_DEPTH; k++) pool_used[k] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && cmd_queue.size() == 0 && !push &&
                 expected_results.size() == 0) && cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
        end else begin
            repeat (300) @(posedge i_clk);
            $display("Checked %0d results, %0d of them pool-full, with one long", results_seen,
                     pool_full_seen);
            $display("receiver hold-off and random stalls on both sides.");
            if (errors == 0 && expected_results.size() == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[priority_mailbox_engine_top.f]
sv/pme_pkg.sv
sv/pme_ram.sv
sv/pme_front.sv
sv/pme_resq.sv
sv/pme_back.sv
sv/priority_mailbox_engine_top.sv
tb/tb_priority_mailbox_engine_top.sv
